// File: hdl/afc_pkg.sv
// Package for the box-versus-frustum classifier: field types, register codes and verdicts.
package afc_pkg;

    // Widths of the coordinate and plane fields.
    localparam int COORD_W     = 16;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 64;
    localparam int COUNT_W     = 3;
    localparam int VERDICT_W   = 2;

    // Default number of stored planes.
    localparam int MAX_PLANES_DEF = 6;

    // Reset value of the plane count register.
    localparam logic [COUNT_W-1:0] PLANE_COUNT_RESET = 3'd6;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] REG_PLANE_COUNT = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_PLANE_A     = 3'd1;

    // Verdict codes.
    localparam logic [VERDICT_W-1:0] VERDICT_OUTSIDE   = 2'd0;
    localparam logic [VERDICT_W-1:0] VERDICT_INTERSECT = 2'd1;
    localparam logic [VERDICT_W-1:0] VERDICT_INSIDE    = 2'd2;

    typedef logic signed [COORD_W-1:0] coord_t;

    // One plane as packed in its register: nx in the low bits, d in the top bits.
    typedef struct packed {
        coord_t d;
        coord_t nz;
        coord_t ny;
        coord_t nx;
    } plane_t;

endpackage

// File: hdl/aabb_frustum_classify.sv
// Top level of the pipelined axis-aligned box versus frustum plane classifier.

// The block takes one box per clock whenever start is high; busy is always low.
// Each box gets exactly one verdict, shown with a one-cycle done strobe after the box
// has passed the input register, multiply, two add stages and the verdict stage.
// The multiply stage forms n*min and n*max for every axis of every stored plane in
// parallel, so throughput is one box per cycle regardless of the plane count.
// Planes and plane_count are written through the cfg port, which is always ready;
// write them only while no box is in flight.
module aabb_frustum_classify
    import afc_pkg::*;
#(
    parameter int MAX_PLANES = MAX_PLANES_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    // Box command.
    input  logic                   start,
    output logic                   busy,
    input  logic signed [15:0]     min_x,
    input  logic signed [15:0]     min_y,
    input  logic signed [15:0]     min_z,
    input  logic signed [15:0]     max_x,
    input  logic signed [15:0]     max_y,
    input  logic signed [15:0]     max_z,
    // Configuration write channel.
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    // Result.
    output logic                   done,
    output logic [VERDICT_W-1:0]   verdict
);

    localparam int PROD_W = 2 * COORD_W;
    localparam int DSH_W  = COORD_W + 14;
    localparam int PART_W = PROD_W + 1;
    localparam int SUM_W  = PROD_W + 2;
    localparam logic [COUNT_W-1:0] MAX_COUNT = COUNT_W'(MAX_PLANES);

    // Configuration registers.
    logic [COUNT_W-1:0] plane_count_reg;
    plane_t             plane_reg [MAX_PLANES];

    // Stage 1: box corners.
    logic   s1_valid_reg;
    coord_t box_lo_reg [3];
    coord_t box_hi_reg [3];

    // Stage 2: products.
    logic                     s2_valid_reg;
    logic signed [PROD_W-1:0] prod_lo_reg [MAX_PLANES][3];
    logic signed [PROD_W-1:0] prod_hi_reg [MAX_PLANES][3];
    logic signed [DSH_W-1:0]  dsh_reg     [MAX_PLANES];

    // Stage 3: partial sums over x and y, and over z and d.
    logic                     s3_valid_reg;
    logic signed [PART_W-1:0] xy_reg [MAX_PLANES][4];
    logic signed [PART_W-1:0] zd_reg [MAX_PLANES][2];

    // Stage 4: one bit per corner that is behind the plane.
    logic       s4_valid_reg;
    logic [7:0] neg_reg [MAX_PLANES];

    // Stage 5: result.
    logic                 done_reg;
    logic [VERDICT_W-1:0] verdict_reg;
    logic [VERDICT_W-1:0] verdict_next;

    logic                 cfg_we;
    coord_t               norm [MAX_PLANES][3];
    logic [COUNT_W-1:0]   count_sat;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;

    // Configuration writes; indexes with no stored plane are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            plane_count_reg <= PLANE_COUNT_RESET;
            for (int p = 0; p < MAX_PLANES; p++)
            begin
                plane_reg[p] <= '0;
            end
        end
        else if (cfg_we)
        begin
            if (cfg_index == REG_PLANE_COUNT)
            begin
                plane_count_reg <= cfg_data[COUNT_W-1:0];
            end
            for (int p = 0; p < MAX_PLANES; p++)
            begin
                if (cfg_index == REG_PLANE_A + CFG_INDEX_W'(p))
                begin
                    plane_reg[p] <= plane_t'(cfg_data);
                end
            end
        end
    end

    // Normal components arranged by axis.
    always_comb
    begin
        for (int p = 0; p < MAX_PLANES; p++)
        begin
            norm[p][0] = plane_reg[p].nx;
            norm[p][1] = plane_reg[p].ny;
            norm[p][2] = plane_reg[p].nz;
        end
    end

    // Valid bits travel with the words down the pipeline.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= start && !busy;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
            done_reg     <= s4_valid_reg;
        end
    end

    // Stage 1 captures the box.
    always_ff @(posedge clk)
    begin
        box_lo_reg[0] <= min_x;
        box_lo_reg[1] <= min_y;
        box_lo_reg[2] <= min_z;
        box_hi_reg[0] <= max_x;
        box_hi_reg[1] <= max_y;
        box_hi_reg[2] <= max_z;
    end

    // Stage 2 multiplies each normal component by the min and max coordinate.
    always_ff @(posedge clk)
    begin
        for (int p = 0; p < MAX_PLANES; p++)
        begin
            for (int a = 0; a < 3; a++)
            begin
                prod_lo_reg[p][a] <= PROD_W'(norm[p][a]) * PROD_W'(box_lo_reg[a]);
                prod_hi_reg[p][a] <= PROD_W'(norm[p][a]) * PROD_W'(box_hi_reg[a]);
            end
            dsh_reg[p] <= $signed({plane_reg[p].d, 14'b0});
        end
    end

    // Stage 3 forms the four x-y combinations and the two z-plus-d terms.
    always_ff @(posedge clk)
    begin
        for (int p = 0; p < MAX_PLANES; p++)
        begin
            xy_reg[p][0] <= PART_W'(prod_lo_reg[p][0]) + PART_W'(prod_lo_reg[p][1]);
            xy_reg[p][1] <= PART_W'(prod_hi_reg[p][0]) + PART_W'(prod_lo_reg[p][1]);
            xy_reg[p][2] <= PART_W'(prod_lo_reg[p][0]) + PART_W'(prod_hi_reg[p][1]);
            xy_reg[p][3] <= PART_W'(prod_hi_reg[p][0]) + PART_W'(prod_hi_reg[p][1]);
            zd_reg[p][0] <= PART_W'(prod_lo_reg[p][2]) + PART_W'(dsh_reg[p]);
            zd_reg[p][1] <= PART_W'(prod_hi_reg[p][2]) + PART_W'(dsh_reg[p]);
        end
    end

    // Stage 4 completes each corner sum and keeps only its sign.
    always_ff @(posedge clk)
    begin
        for (int p = 0; p < MAX_PLANES; p++)
        begin
            for (int c = 0; c < 8; c++)
            begin
                logic signed [SUM_W-1:0] sum;
                sum = SUM_W'(xy_reg[p][c % 4]) + SUM_W'(zd_reg[p][c / 4]);
                neg_reg[p][c] <= sum[SUM_W-1];
            end
        end
    end

    // Active plane count, saturated to the number of stored planes.
    assign count_sat = (plane_count_reg > MAX_COUNT) ? MAX_COUNT : plane_count_reg;

    // Stage 5: outside wins over intersecting, which wins over inside.
    always_comb
    begin
        logic any_out;
        logic any_neg;
        any_out = 1'b0;
        any_neg = 1'b0;
        for (int p = 0; p < MAX_PLANES; p++)
        begin
            if (COUNT_W'(p) < count_sat)
            begin
                any_out = any_out | (&neg_reg[p]);
                any_neg = any_neg | (|neg_reg[p]);
            end
        end
        if (any_out)
        begin
            verdict_next = VERDICT_OUTSIDE;
        end
        else if (any_neg)
        begin
            verdict_next = VERDICT_INTERSECT;
        end
        else
        begin
            verdict_next = VERDICT_INSIDE;
        end
    end

    always_ff @(posedge clk)
    begin
        verdict_reg <= verdict_next;
    end

    assign done    = done_reg;
    assign verdict = verdict_reg;

`ifndef NO_ASSERTIONS
    // Every strobe comes from a box that was taken.
    a_done_has_box: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, 5))
        else $error("done without a matching box");

    // With no active planes every box is inside.
    a_no_planes_inside: assert property (@(posedge clk) disable iff (!rst_n)
        (done && plane_count_reg == '0) |-> (verdict == VERDICT_INSIDE))
        else $error("verdict not inside with no active planes");

    // A write of the plane count lands in the register at the next edge.
    a_count_write: assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_valid && cfg_ready && cfg_index == REG_PLANE_COUNT)
        |=> (plane_count_reg == $past(cfg_data[COUNT_W-1:0])))
        else $error("plane count write lost");
`endif

endmodule
